/* hw/rtl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Request, response and configuration types and constants for the
// lru key-value cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE     = '1;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

endpackage

/* hw/rtl/lru_key_value_cache_top.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement,
// built as a chain of slot cells that a search token walks through.
// ----------------------------------------------------------------------------
//
//   channel   ports                         direction  handshake
//   request   start, busy, req_data         in         start & !busy
//   response  rsp_valid, rsp_data           out        one-cycle strobe
//   config    csr_wr_en, csr_wr_data        in         write enable
//
// the search token moves one cell per cycle along the chain, then the
// update is broadcast to all cells
// busy is registered: it goes high after acceptance and stays high until the update cycle ends
// a get response appears on the cycle after the update, for one cycle
// reset clears all valid flags, ranks, occupancy and sets capacity to 16
// the response side cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_top
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
   localparam int TOK_W = 5 * IDX_W + KEY_W + VAL_W + 4;

   typedef struct packed {
      logic              active;
      logic [KEY_W-1:0]  key;
      logic              found;
      logic [IDX_W-1:0]  hit_idx;
      logic [VAL_W-1:0]  hit_value;
      logic [IDX_W-1:0]  hit_rank;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic              lru_found;
      logic [IDX_W-1:0]  lru_idx;
      logic [IDX_W-1:0]  lru_rank;
   } token_type;

   typedef struct packed {
      logic              touch;
      logic              insert;
      logic              write;
      logic [IDX_W-1:0]  slot;
      logic [IDX_W-1:0]  ref_rank;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   logic [TOK_W-1:0] chain [0:ENTRIES];
   token_type        tok_head;
   token_type        tok_tail;
   cmd_type          cmd;

   logic             accept;
   logic             busy_ff;
   logic             busy_in;
   req_type          req_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [CMP_W-1:0] eff_cap;
   logic             below_cap;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      tok_head        = '0;
      tok_head.active = accept;
      tok_head.key    = req_data.key;
   end

   assign chain[0] = tok_head;
   assign tok_tail = chain[ENTRIES];

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkv_cell #(
         .INDEX   (g),
         .IDX_W   (IDX_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1]),
         .cmd_in  (cmd)
      );
   end

   // effective capacity, clamped to 1..ENTRIES
   always_comb begin
      eff_cap = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end
      if (eff_cap > ENTRIES_C) begin
         eff_cap = ENTRIES_C;
      end
   end

   assign below_cap = CMP_W'(occ_ff) < eff_cap;

   // decision when the token leaves the chain
   always_comb begin
      cmd          = '0;
      cmd.key      = req_ff.key;
      cmd.value    = req_ff.value;
      occ_in       = occ_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (tok_tail.active) begin
         if (req_ff.kind == KIND_GET) begin
            rsp_valid_in = 1'b1;
            if (tok_tail.found) begin
               cmd.touch         = 1'b1;
               cmd.slot          = tok_tail.hit_idx;
               cmd.ref_rank      = tok_tail.hit_rank;
               rsp_in.hit        = 1'b1;
               rsp_in.read_value = tok_tail.hit_value;
            end else begin
               rsp_in.hit        = 1'b0;
               rsp_in.read_value = MISS_VALUE;
            end
         end else if (tok_tail.found) begin
            cmd.touch    = 1'b1;
            cmd.write    = 1'b1;
            cmd.slot     = tok_tail.hit_idx;
            cmd.ref_rank = tok_tail.hit_rank;
         end else if (below_cap && tok_tail.free_found) begin
            cmd.insert = 1'b1;
            cmd.write  = 1'b1;
            cmd.slot   = tok_tail.free_idx;
            occ_in     = occ_ff + 1'b1;
         end else if (tok_tail.lru_found) begin
            cmd.touch    = 1'b1;
            cmd.write    = 1'b1;
            cmd.slot     = tok_tail.lru_idx;
            cmd.ref_rank = tok_tail.lru_rank;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok_tail.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // checks

   a_rsp_after_get : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(tok_tail.active) && $past(req_ff.kind) == KIND_GET)
      else $error("response without a finished get");

   a_miss_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == MISS_VALUE)
      else $error("miss response with wrong value");

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occ_ff) <= ENTRIES_C)
      else $error("occupancy above slot count");

   a_occ_step : assert property (@(posedge clock) disable iff (reset)
      tok_tail.active && cmd.insert |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("occupancy not advanced on insert");

   a_token_single : assert property (@(posedge clock) disable iff (reset)
      tok_tail.active |-> busy_ff)
      else $error("token left the chain while idle");

endmodule

/* hw/rtl/lkv_cell.sv */
// ----------------------------------------------------------------------------
// lkv_cell
// One cache slot: holds key, value, valid flag and recency rank, folds its
// contents into the search token passing through and applies update commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_cell
   import lkv_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int IDX_W   = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [5*IDX_W+KEY_W+VAL_W+4-1:0]       tok_in,
   output logic [5*IDX_W+KEY_W+VAL_W+4-1:0]       tok_out,
   input  logic [IDX_W*2+KEY_W+VAL_W+3-1:0]       cmd_in
);

   typedef struct packed {
      logic              active;
      logic [KEY_W-1:0]  key;
      logic              found;
      logic [IDX_W-1:0]  hit_idx;
      logic [VAL_W-1:0]  hit_value;
      logic [IDX_W-1:0]  hit_rank;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic              lru_found;
      logic [IDX_W-1:0]  lru_idx;
      logic [IDX_W-1:0]  lru_rank;
   } token_type;

   typedef struct packed {
      logic              touch;
      logic              insert;
      logic              write;
      logic [IDX_W-1:0]  slot;
      logic [IDX_W-1:0]  ref_rank;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   token_type        tok_i;
   token_type        tok_ff;
   token_type        tok_in_c;
   cmd_type          cmd;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   logic             valid_ff;
   logic             valid_in;
   logic [IDX_W-1:0] rank_ff;
   logic [IDX_W-1:0] rank_in;
   logic             sel;

   assign tok_i   = tok_in;
   assign cmd     = cmd_in;
   assign tok_out = tok_ff;
   assign sel     = (cmd.slot == MY_IDX);

   // fold this slot into the passing search
   always_comb begin
      tok_in_c = tok_i;
      if (tok_i.active) begin
         if (valid_ff && key_ff == tok_i.key && !tok_i.found) begin
            tok_in_c.found     = 1'b1;
            tok_in_c.hit_idx   = MY_IDX;
            tok_in_c.hit_value = value_ff;
            tok_in_c.hit_rank  = rank_ff;
         end
         if (!valid_ff && !tok_i.free_found) begin
            tok_in_c.free_found = 1'b1;
            tok_in_c.free_idx   = MY_IDX;
         end
         if (valid_ff && (!tok_i.lru_found || rank_ff > tok_i.lru_rank)) begin
            tok_in_c.lru_found = 1'b1;
            tok_in_c.lru_idx   = MY_IDX;
            tok_in_c.lru_rank  = rank_ff;
         end
      end
   end

   // slot update
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.insert && valid_ff) begin
         rank_in = rank_ff + 1'b1;
      end
      if (cmd.touch && valid_ff && !sel && rank_ff < cmd.ref_rank) begin
         rank_in = rank_ff + 1'b1;
      end
      if ((cmd.touch || cmd.insert) && sel) begin
         rank_in  = '0;
         valid_in = 1'b1;
      end
      if (cmd.write && sel) begin
         key_in   = cmd.key;
         value_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         tok_ff   <= tok_in_c;
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

/* tb/lru_key_value_cache_top_tb.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb
// Self-checking bench for the lru key-value cache. A short table of get
// and put requests covers the key and value extremes, overwrite, eviction
// and capacity corner settings. It is followed by random phases at
// several capacities, with keys drawn from small pools so that hits and
// evictions are frequent. Every get response is checked against the table's
// expected result where a row gives one, else against a behavioural cache in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
   import lkv_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 218;
   localparam int ROWS        = 24;
   localparam int POOL_MAX    = 40;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic             set_cap;
      logic [CAP_W-1:0] cap;
      req_type          req;
      logic             typed;
      rsp_type          want;
   } step_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   // shadow copy of the cache
   logic [KEY_W-1:0] slot_key  [ENTRIES];
   logic [VAL_W-1:0] slot_val  [ENTRIES];
   bit               slot_used [ENTRIES];
   int               slot_age  [ENTRIES];
   int               fill_count;
   logic [CAP_W-1:0] cap_reg;

   rsp_type          expected_reads [$];
   int               mismatch_count = 0;
   int               stall_cycles   = 0;
   step_row_type     directed_rows [ROWS];
   int               phase_caps [PHASES] = '{16, 1, 4, 0, 31, 9, 2, 16};

   always #10 clock = ~clock;

   lru_key_value_cache_top #(
      .ENTRIES(ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   function automatic int usable_capacity(input logic [CAP_W-1:0] c);
      if (c == 0) return 1;
      if (c > ENTRIES) return ENTRIES;
      return int'(c);
   endfunction

   function automatic void promote(input int s);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
            slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   // applies one request to the shadow cache, returns 1 when a response follows
   function automatic bit cache_access(input req_type r, output rsp_type o);
      int found;
      int slot;
      found = -1;
      slot  = -1;
      o     = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_used[i] && slot_key[i] == r.key)
            found = i;
      if (r.kind == KIND_GET) begin
         if (found >= 0) begin
            promote(found);
            o.hit        = 1'b1;
            o.read_value = slot_val[found];
         end else begin
            o.hit        = 1'b0;
            o.read_value = MISS_VALUE;
         end
         return 1'b1;
      end
      if (found >= 0) begin
         slot_val[found] = r.value;
         promote(found);
         return 1'b0;
      end
      if (fill_count < usable_capacity(cap_reg))
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !slot_used[i])
               slot = i;
      if (slot >= 0) begin
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
               slot_age[i]++;
         slot_used[slot] = 1'b1;
         slot_age[slot]  = 0;
         fill_count++;
      end else begin
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && (slot < 0 || slot_age[i] > slot_age[slot]))
               slot = i;
         if (slot < 0)
            return 1'b0;
         promote(slot);
      end
      slot_key[slot] = r.key;
      slot_val[slot] = r.value;
      return 1'b0;
   endfunction

   task automatic issue_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type got;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      if (cache_access(r, got))
         expected_reads.push_back(typed ? want : got);
   endtask

   task automatic idle_gap();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         len = 0;
      else if (pick < 85)
         len = $urandom_range(1, 3);
      else if (pick < 97)
         len = $urandom_range(4, 24);
      else
         len = $urandom_range(25, 60);
      if (len > 0) begin
         start <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (ENTRIES + 4) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_reg = c;
   endtask

   // response checker
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_reads.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response hit=%0b value=%h",
                        rsp_data.hit, rsp_data.read_value);
         end else begin
            want = expected_reads.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                           want.hit, want.read_value, rsp_data.hit, rsp_data.read_value);
            end
         end
      end
   end

   // watchdog on cycles with no request and no response
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      req_type          r;
      int               pool_size;
      int               burst;
      int               sel;
      logic [CAP_W-1:0] cap_v;
      logic [KEY_W-1:0] key_pool [POOL_MAX];

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      burst       = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key[i]  = '0;
         slot_val[i]  = '0;
         slot_used[i] = 1'b0;
         slot_age[i]  = 0;
      end
      fill_count = 0;
      cap_reg    = CAPACITY_RESET;

      directed_rows = '{
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000000, 32'h00000000}, 1'b1, '{1'b0, MISS_VALUE}},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h80000000, 32'h00000000}, 1'b1, '{1'b0, MISS_VALUE}},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'h00000000, 32'h00000000}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'hffffffff, 32'hffffffff}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h80000000, 32'h00000000}, 1'b1, '{1'b1, 32'h7fffffff}},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h7fffffff, 32'h00000000}, 1'b1, '{1'b1, 32'h80000000}},
         '{1'b0, 5'd0,  '{KIND_GET, 32'hffffffff, 32'h00000000}, 1'b1, '{1'b1, 32'hffffffff}},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000001, 32'h00000000}, 1'b1, '{1'b0, MISS_VALUE}},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'h80000000, 32'h12345678}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h80000000, 32'hffffffff}, 1'b0, '0},
         '{1'b1, 5'd2,  '{KIND_PUT, 32'h00000055, 32'h00000001}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000000, 32'h00000000}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000055, 32'h00000000}, 1'b0, '0},
         '{1'b1, 5'd0,  '{KIND_PUT, 32'h00000066, 32'h00000002}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000066, 32'h00000000}, 1'b0, '0},
         '{1'b1, 5'd31, '{KIND_PUT, 32'h00000077, 32'h00000003}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000077, 32'h00000000}, 1'b0, '0},
         '{1'b1, 5'd1,  '{KIND_PUT, 32'h00000088, 32'h00000004}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_PUT, 32'h00000099, 32'h00000005}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000088, 32'h00000000}, 1'b0, '0},
         '{1'b0, 5'd0,  '{KIND_GET, 32'h00000099, 32'h00000000}, 1'b0, '0},
         '{1'b1, 5'd16, '{KIND_GET, 32'h7fffffff, 32'h00000000}, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < ROWS; i++) begin
         if (directed_rows[i].set_cap)
            write_capacity(directed_rows[i].cap);
         issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         if (i + 1 < ROWS && !directed_rows[i + 1].set_cap)
            idle_gap();
      end

      // random phases, one capacity each
      for (int ph = 0; ph < PHASES; ph++) begin
         cap_v = (ph == PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(phase_caps[ph]);
         write_capacity(cap_v);
         pool_size = usable_capacity(cap_v);
         pool_size = pool_size + $urandom_range(1, pool_size + 4);
         if (pool_size > POOL_MAX)
            pool_size = POOL_MAX;
         for (int k = 0; k < POOL_MAX; k++)
            key_pool[k] = $urandom;
         key_pool[0] = 32'h80000000;
         key_pool[1] = 32'h7fffffff;
         key_pool[2] = 32'h00000000;
         key_pool[3] = 32'hffffffff;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
            sel = $urandom_range(0, 99);
            r.key = (sel < 6) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
            sel = $urandom_range(0, 99);
            if (sel < 3)
               r.value = 32'h80000000;
            else if (sel < 6)
               r.value = 32'h7fffffff;
            else if (sel < 9)
               r.value = '1;
            else
               r.value = $urandom;
            issue_request(r, 1'b0, '0);
            if (n == PHASE_ITEMS - 1) begin
               // next phase drains before its register write
            end else if ($urandom_range(0, 199) == 0) begin
               wait_drained();
            end else if (burst > 0) begin
               burst--;
            end else if ($urandom_range(0, 19) == 0) begin
               burst = $urandom_range(10, 40);
            end else begin
               idle_gap();
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
